FILE: rtl/s5rp_pkg.sv
// SOCKS5 request parser: shared widths, parse phase codes, protocol constants
// and result codes. No dependencies.

package s5rp_pkg;

   localparam int BYTE_W   = 8;
   localparam int PORT_W   = 16;
   localparam int STATUS_W = 2;
   localparam int KIND_W   = 3;
   localparam int REP_W    = 4;
   localparam int PHASE_W  = 4;

   // parse phases
   localparam logic [PHASE_W-1:0] PH_VERSION  = 4'd0;
   localparam logic [PHASE_W-1:0] PH_CMD      = 4'd1;
   localparam logic [PHASE_W-1:0] PH_RSV      = 4'd2;
   localparam logic [PHASE_W-1:0] PH_ATYP     = 4'd3;
   localparam logic [PHASE_W-1:0] PH_FQDN_LEN = 4'd4;
   localparam logic [PHASE_W-1:0] PH_ADDR     = 4'd5;
   localparam logic [PHASE_W-1:0] PH_PORT_HI  = 4'd6;
   localparam logic [PHASE_W-1:0] PH_PORT_LO  = 4'd7;
   localparam logic [PHASE_W-1:0] PH_DONE     = 4'd8;
   localparam logic [PHASE_W-1:0] PH_ERR_VER  = 4'd9;
   localparam logic [PHASE_W-1:0] PH_ERR_RSV  = 4'd10;
   localparam logic [PHASE_W-1:0] PH_ERR_CMD  = 4'd11;
   localparam logic [PHASE_W-1:0] PH_ERR_ADDR = 4'd12;

   // channel commands
   localparam logic CMD_FEED    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   // protocol bytes
   localparam logic [BYTE_W-1:0] SOCKS_VERSION = 8'h05;
   localparam logic [BYTE_W-1:0] SOCKS_CONNECT = 8'h01;
   localparam logic [BYTE_W-1:0] SOCKS_RSV     = 8'h00;
   localparam logic [BYTE_W-1:0] ATYP_IPV4     = 8'h01;
   localparam logic [BYTE_W-1:0] ATYP_DOMAIN   = 8'h03;
   localparam logic [BYTE_W-1:0] ATYP_IPV6     = 8'h04;
   localparam logic [BYTE_W-1:0] IPV4_LEN      = 8'd4;
   localparam logic [BYTE_W-1:0] IPV6_LEN      = 8'd16;
   localparam logic [BYTE_W-1:0] DOMAIN_MIN    = 8'h21;
   localparam logic [BYTE_W-1:0] DOMAIN_DEL    = 8'h7F;

   // status codes
   localparam logic [STATUS_W-1:0] ST_PARSING  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_COMPLETE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;

   // error kinds
   localparam logic [KIND_W-1:0] ERR_NONE    = 3'd0;
   localparam logic [KIND_W-1:0] ERR_VERSION = 3'd1;
   localparam logic [KIND_W-1:0] ERR_RSV     = 3'd2;
   localparam logic [KIND_W-1:0] ERR_CMD     = 3'd3;
   localparam logic [KIND_W-1:0] ERR_ADDR    = 3'd4;

   // reply codes
   localparam logic [REP_W-1:0] REP_SUCCESS  = 4'd0;
   localparam logic [REP_W-1:0] REP_GENERAL  = 4'd1;
   localparam logic [REP_W-1:0] REP_CMD_NS   = 4'd7;
   localparam logic [REP_W-1:0] REP_ATYP_NS  = 4'd8;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [KIND_W-1:0]   error_kind;
      logic [REP_W-1:0]    reply_code;
      logic [BYTE_W-1:0]   address_type;
      logic [BYTE_W-1:0]   address_length;
      logic                address_byte_valid;
      logic [BYTE_W-1:0]   address_byte;
      logic [BYTE_W-1:0]   address_index;
      logic [PORT_W-1:0]   dest_port;
   } rsp_payload_type;

endpackage

FILE: rtl/s5rp_if.sv
// Valid/ready channel interfaces for the SOCKS5 request parser.
// Depends on s5rp_pkg for field widths.

interface s5rp_req_if
   import s5rp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output cmd, output in_byte, input ready);
   modport sink   (input valid, input cmd, input in_byte, output ready);
endinterface

interface s5rp_rsp_if
   import s5rp_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [KIND_W-1:0]   error_kind;
   logic [REP_W-1:0]    reply_code;
   logic [BYTE_W-1:0]   address_type;
   logic [BYTE_W-1:0]   address_length;
   logic                address_byte_valid;
   logic [BYTE_W-1:0]   address_byte;
   logic [BYTE_W-1:0]   address_index;
   logic [PORT_W-1:0]   dest_port;

   modport source (output valid, output status, output error_kind, output reply_code,
                   output address_type, output address_length,
                   output address_byte_valid, output address_byte,
                   output address_index, output dest_port, input ready);
   modport sink   (input valid, input status, input error_kind, input reply_code,
                   input address_type, input address_length,
                   input address_byte_valid, input address_byte,
                   input address_index, input dest_port, output ready);
endinterface

FILE: rtl/socks5_request_parser_unit.sv
// SOCKS5 request parser, one request byte per beat.
// Each accepted req beat's rsp beat is loaded into the output register on accept.
// Throughput: 1 beat per cycle unless rsp_ch stalls; the output register accepts a
// new beat in the same cycle its current one is taken.
// Reset (synchronous, active high) returns the parser to the version phase and
// empties the output register.

module socks5_request_parser_unit
   import s5rp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   s5rp_req_if.sink    req_ch,
   s5rp_rsp_if.source  rsp_ch
);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [BYTE_W-1:0]  atyp_ff, atyp_in;
   logic [BYTE_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0]  port_hi_ff, port_hi_in;
   logic [PORT_W-1:0]  port_ff, port_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_ff, rsp_in;

   logic               accept;
   logic [BYTE_W-1:0]  c;
   logic [BYTE_W-1:0]  pos_inc;
   logic               char_ok;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign c            = req_ch.in_byte;
   assign pos_inc      = pos_ff + 8'd1;
   assign char_ok      = (c >= DOMAIN_MIN) && (c != DOMAIN_DEL);

   always_comb begin
      phase_in   = phase_ff;
      atyp_in    = atyp_ff;
      len_in     = len_ff;
      pos_in     = pos_ff;
      port_hi_in = port_hi_ff;
      port_in    = port_ff;
      rsp_in     = '0;

      if (req_ch.cmd == CMD_RESTART) begin
         phase_in   = PH_VERSION;
         atyp_in    = '0;
         len_in     = '0;
         pos_in     = '0;
         port_hi_in = '0;
         port_in    = '0;
      end else begin
         unique case (phase_ff)
            PH_VERSION: phase_in = (c == SOCKS_VERSION) ? PH_CMD : PH_ERR_VER;
            PH_CMD:     phase_in = (c == SOCKS_CONNECT) ? PH_RSV : PH_ERR_CMD;
            PH_RSV:     phase_in = (c == SOCKS_RSV) ? PH_ATYP : PH_ERR_RSV;
            PH_ATYP: begin
               atyp_in = c;
               priority if (c == ATYP_IPV4) begin
                  pos_in   = '0;
                  len_in   = IPV4_LEN;
                  phase_in = PH_ADDR;
               end else if (c == ATYP_IPV6) begin
                  pos_in   = '0;
                  len_in   = IPV6_LEN;
                  phase_in = PH_ADDR;
               end else if (c == ATYP_DOMAIN) begin
                  phase_in = PH_FQDN_LEN;
               end else begin
                  phase_in = PH_ERR_ADDR;
               end
            end
            PH_FQDN_LEN: begin
               len_in   = c;
               pos_in   = '0;
               phase_in = (c == 8'd0) ? PH_ERR_ADDR : PH_ADDR;
            end
            PH_ADDR: begin
               // reject bad domain characters without delivering them
               if (atyp_ff == ATYP_DOMAIN && !char_ok) begin
                  phase_in = PH_ERR_ADDR;
               end else begin
                  rsp_in.address_byte_valid = 1'b1;
                  rsp_in.address_byte       = c;
                  rsp_in.address_index      = pos_ff;
                  pos_in                    = pos_inc;
                  if (pos_inc == len_ff) begin
                     phase_in = PH_PORT_HI;
                  end
               end
            end
            PH_PORT_HI: begin
               port_hi_in = c;
               phase_in   = PH_PORT_LO;
            end
            PH_PORT_LO: begin
               port_in  = {port_hi_ff, c};
               phase_in = PH_DONE;
            end
            // terminal phases: hold everything
            default: phase_in = phase_ff;
         endcase
      end

      unique case (phase_in)
         PH_DONE: begin
            rsp_in.status     = ST_COMPLETE;
            rsp_in.error_kind = ERR_NONE;
            rsp_in.reply_code = REP_SUCCESS;
         end
         PH_ERR_VER: begin
            rsp_in.status     = ST_REJECTED;
            rsp_in.error_kind = ERR_VERSION;
            rsp_in.reply_code = REP_GENERAL;
         end
         PH_ERR_RSV: begin
            rsp_in.status     = ST_REJECTED;
            rsp_in.error_kind = ERR_RSV;
            rsp_in.reply_code = REP_GENERAL;
         end
         PH_ERR_CMD: begin
            rsp_in.status     = ST_REJECTED;
            rsp_in.error_kind = ERR_CMD;
            rsp_in.reply_code = REP_CMD_NS;
         end
         PH_ERR_ADDR: begin
            rsp_in.status     = ST_REJECTED;
            rsp_in.error_kind = ERR_ADDR;
            rsp_in.reply_code = REP_ATYP_NS;
         end
         default: begin
            rsp_in.status     = ST_PARSING;
            rsp_in.error_kind = ERR_NONE;
            rsp_in.reply_code = REP_SUCCESS;
         end
      endcase

      rsp_in.address_type   = atyp_in;
      rsp_in.address_length = len_in;
      rsp_in.dest_port      = (phase_in == PH_DONE) ? port_in : '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_VERSION;
         atyp_ff      <= '0;
         len_ff       <= '0;
         pos_ff       <= '0;
         port_hi_ff   <= '0;
         port_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff   <= phase_in;
            atyp_ff    <= atyp_in;
            len_ff     <= len_in;
            pos_ff     <= pos_in;
            port_hi_ff <= port_hi_in;
            port_ff    <= port_in;
         end
      end
   end

   // payload register: load on accept, hold while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.status             = rsp_ff.status;
   assign rsp_ch.error_kind         = rsp_ff.error_kind;
   assign rsp_ch.reply_code         = rsp_ff.reply_code;
   assign rsp_ch.address_type       = rsp_ff.address_type;
   assign rsp_ch.address_length     = rsp_ff.address_length;
   assign rsp_ch.address_byte_valid = rsp_ff.address_byte_valid;
   assign rsp_ch.address_byte       = rsp_ff.address_byte;
   assign rsp_ch.address_index      = rsp_ff.address_index;
   assign rsp_ch.dest_port          = rsp_ff.dest_port;

endmodule

FILE: tb/socks5_request_parser_unit_tb.sv
// Testbench for socks5_request_parser_unit: a directed table, then random
// requests, checked beat by beat against an in-bench parser model.
// Depends on s5rp_pkg and the channel interfaces in s5rp_if.

module socks5_request_parser_unit_tb
   import s5rp_pkg::*;
();

   localparam int ITEM_TARGET    = 800;
   localparam int CALM_AFTER     = 750;
   localparam int HOLD_CYCLES    = 48;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic                cmd;
      logic [BYTE_W-1:0]   data;
      logic                pinned;
      logic [STATUS_W-1:0] status;
      logic [KIND_W-1:0]   error_kind;
      logic [REP_W-1:0]    reply_code;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   s5rp_req_if req_bus ();
   s5rp_rsp_if rsp_bus ();

   socks5_request_parser_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // parser model state
   logic [PHASE_W-1:0] p_phase   = PH_VERSION;
   logic [BYTE_W-1:0]  p_atyp    = '0;
   logic [BYTE_W-1:0]  p_len     = '0;
   logic [BYTE_W-1:0]  p_pos     = '0;
   logic [BYTE_W-1:0]  p_port_hi = '0;
   logic [PORT_W-1:0]  p_port    = '0;

   rsp_payload_type pending_results [$];
   stim_row_type    sent_rows [$];

   int taken_reqs     = 0;
   int results_seen   = 0;
   int fed_items      = 0;
   int ignored_items  = 0;
   int mismatches     = 0;
   int streamed_bytes = 0;
   int completes      = 0;
   int rejects        = 0;
   int stalled_cycles = 0;
   bit long_domain_sent = 1'b0;

   // directed rows; status, kind and reply are pinned where obvious
   stim_row_type directed_rows [28] = '{
      '{CMD_FEED,    8'h00,         1'b1, ST_REJECTED, ERR_VERSION, REP_GENERAL},
      '{CMD_FEED,    8'hFF,         1'b1, ST_REJECTED, ERR_VERSION, REP_GENERAL},
      '{CMD_RESTART, 8'hFF,         1'b1, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    SOCKS_VERSION, 1'b0, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    8'h02,         1'b1, ST_REJECTED, ERR_CMD,     REP_CMD_NS},
      '{CMD_RESTART, 8'h00,         1'b1, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    SOCKS_VERSION, 1'b0, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    SOCKS_CONNECT, 1'b0, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    8'hFF,         1'b1, ST_REJECTED, ERR_RSV,     REP_GENERAL},
      '{CMD_RESTART, 8'h5A,         1'b1, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    SOCKS_VERSION, 1'b0, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    SOCKS_CONNECT, 1'b0, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    SOCKS_RSV,     1'b0, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    8'h00,         1'b1, ST_REJECTED, ERR_ADDR,    REP_ATYP_NS},
      '{CMD_RESTART, 8'hA5,         1'b1, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    SOCKS_VERSION, 1'b0, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    SOCKS_CONNECT, 1'b0, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    SOCKS_RSV,     1'b0, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    ATYP_DOMAIN,   1'b0, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    8'h00,         1'b1, ST_REJECTED, ERR_ADDR,    REP_ATYP_NS},
      '{CMD_RESTART, 8'h00,         1'b1, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    SOCKS_VERSION, 1'b0, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    SOCKS_CONNECT, 1'b0, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    SOCKS_RSV,     1'b0, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    ATYP_DOMAIN,   1'b0, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    8'h02,         1'b0, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    DOMAIN_MIN,    1'b0, ST_PARSING,  ERR_NONE,    REP_SUCCESS},
      '{CMD_FEED,    DOMAIN_DEL,    1'b1, ST_REJECTED, ERR_ADDR,    REP_ATYP_NS}
   };

   // Advance the parser model by one beat and return the result it reports.
   function automatic rsp_payload_type parse_socks_byte(input logic cmd,
                                                        input logic [BYTE_W-1:0] b);
      rsp_payload_type r;
      r = '0;
      if (cmd == CMD_RESTART) begin
         p_phase   = PH_VERSION;
         p_atyp    = '0;
         p_len     = '0;
         p_pos     = '0;
         p_port_hi = '0;
         p_port    = '0;
      end else begin
         case (p_phase)
            PH_VERSION: p_phase = (b == SOCKS_VERSION) ? PH_CMD : PH_ERR_VER;
            PH_CMD:     p_phase = (b == SOCKS_CONNECT) ? PH_RSV : PH_ERR_CMD;
            PH_RSV:     p_phase = (b == SOCKS_RSV) ? PH_ATYP : PH_ERR_RSV;
            PH_ATYP: begin
               p_atyp = b;
               if (b == ATYP_IPV4 || b == ATYP_IPV6) begin
                  p_pos   = '0;
                  p_len   = (b == ATYP_IPV4) ? IPV4_LEN : IPV6_LEN;
                  p_phase = PH_ADDR;
               end else if (b == ATYP_DOMAIN) begin
                  p_phase = PH_FQDN_LEN;
               end else begin
                  p_phase = PH_ERR_ADDR;
               end
            end
            PH_FQDN_LEN: begin
               p_len   = b;
               p_pos   = '0;
               p_phase = (b == '0) ? PH_ERR_ADDR : PH_ADDR;
            end
            PH_ADDR: begin
               if (p_atyp == ATYP_DOMAIN && (b < DOMAIN_MIN || b == DOMAIN_DEL)) begin
                  p_phase = PH_ERR_ADDR;
               end else begin
                  r.address_byte_valid = 1'b1;
                  r.address_byte       = b;
                  r.address_index      = p_pos;
                  p_pos = p_pos + 1'b1;
                  if (p_pos == p_len) p_phase = PH_PORT_HI;
               end
            end
            PH_PORT_HI: begin
               p_port_hi = b;
               p_phase   = PH_PORT_LO;
            end
            PH_PORT_LO: begin
               p_port  = {p_port_hi, b};
               p_phase = PH_DONE;
            end
            default: ;
         endcase
      end
      case (p_phase)
         PH_DONE: begin
            r.status     = ST_COMPLETE;
            r.error_kind = ERR_NONE;
            r.reply_code = REP_SUCCESS;
         end
         PH_ERR_VER: begin
            r.status     = ST_REJECTED;
            r.error_kind = ERR_VERSION;
            r.reply_code = REP_GENERAL;
         end
         PH_ERR_RSV: begin
            r.status     = ST_REJECTED;
            r.error_kind = ERR_RSV;
            r.reply_code = REP_GENERAL;
         end
         PH_ERR_CMD: begin
            r.status     = ST_REJECTED;
            r.error_kind = ERR_CMD;
            r.reply_code = REP_CMD_NS;
         end
         PH_ERR_ADDR: begin
            r.status     = ST_REJECTED;
            r.error_kind = ERR_ADDR;
            r.reply_code = REP_ATYP_NS;
         end
         default: ;
      endcase
      r.address_type   = p_atyp;
      r.address_length = p_len;
      r.dest_port      = (p_phase == PH_DONE) ? p_port : '0;
      return r;
   endfunction

   function automatic string result_text(input rsp_payload_type r);
      return $sformatf({"st=%0d kind=%0d rep=%0d atyp=%02h alen=%0d",
                        " abv=%0b ab=%02h aidx=%0d port=%04h"},
                       r.status, r.error_kind, r.reply_code, r.address_type,
                       r.address_length, r.address_byte_valid, r.address_byte,
                       r.address_index, r.dest_port);
   endfunction

   // idle bursts come and go in windows and stop for the tail of the run
   function automatic bit bursty();
      return (taken_reqs < CALM_AFTER) && ((taken_reqs / 64) % 3 != 2);
   endfunction

   function automatic logic [BYTE_W-1:0] other_than(input logic [BYTE_W-1:0] good);
      logic [BYTE_W-1:0] v;
      v = 8'($urandom);
      if (v == good) v = ~v;
      return v;
   endfunction

   // Present one beat, with an optional idle burst first, and hold it until taken.
   task automatic feed(input stim_row_type row);
      int gap;
      // phases from done upward are terminal: a fed byte there changes nothing
      if (row.cmd == CMD_FEED && p_phase >= PH_DONE) ignored_items++;
      fed_items++;
      sent_rows.push_back(row);
      if (bursty() && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_bus.valid   <= 1'b0;
         req_bus.in_byte <= 8'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.cmd     <= row.cmd;
      req_bus.in_byte <= row.data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic feed_byte(input logic cmd, input logic [BYTE_W-1:0] b);
      feed('{cmd, b, 1'b0, ST_PARSING, ERR_NONE, REP_SUCCESS});
   endtask

   // One request: mostly well formed with random content, some broken at one field.
   task automatic send_request();
      int pick;
      int len;
      logic [BYTE_W-1:0] atyp;
      logic [BYTE_W-1:0] b;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 19) != 0) feed_byte(CMD_RESTART, 8'($urandom));
      if ($urandom_range(0, 29) == 0) feed_byte(CMD_RESTART, 8'($urandom));
      if (pick < 8) begin
         feed_byte(CMD_FEED, other_than(SOCKS_VERSION));
         return;
      end
      feed_byte(CMD_FEED, SOCKS_VERSION);
      if (pick < 14) begin
         feed_byte(CMD_FEED, other_than(SOCKS_CONNECT));
         return;
      end
      feed_byte(CMD_FEED, SOCKS_CONNECT);
      if (pick < 20) begin
         feed_byte(CMD_FEED, other_than(SOCKS_RSV));
         return;
      end
      feed_byte(CMD_FEED, SOCKS_RSV);
      if (pick < 27) begin
         atyp = 8'($urandom);
         if (atyp == ATYP_IPV4 || atyp == ATYP_DOMAIN || atyp == ATYP_IPV6)
            atyp = atyp ^ 8'h40;
         feed_byte(CMD_FEED, atyp);
         return;
      end
      case ($urandom_range(0, 2))
         0:       atyp = ATYP_IPV4;
         1:       atyp = ATYP_IPV6;
         default: atyp = ATYP_DOMAIN;
      endcase
      feed_byte(CMD_FEED, atyp);
      if (atyp == ATYP_DOMAIN) begin
         pick = $urandom_range(0, 99);
         if (!long_domain_sent && fed_items > 300) begin
            len = 255;
            long_domain_sent = 1'b1;
         end else if (pick < 4) begin
            len = 0;
         end else if (pick < 12) begin
            len = $urandom_range(13, 48);
         end else begin
            len = $urandom_range(1, 12);
         end
         feed_byte(CMD_FEED, 8'(len));
         if (len == 0) return;
      end else begin
         len = (atyp == ATYP_IPV4) ? IPV4_LEN : IPV6_LEN;
      end
      for (int i = 0; i < len; i++) begin
         // keep the longest name intact so the top index is reached
         if (len < 255 && $urandom_range(0, 99) == 0) begin
            feed_byte(CMD_RESTART, 8'($urandom));
            return;
         end
         if (atyp == ATYP_DOMAIN && len < 255 && $urandom_range(0, 39) == 0) begin
            b = $urandom_range(0, 1) ? DOMAIN_DEL : 8'($urandom_range(0, DOMAIN_MIN - 1));
            feed_byte(CMD_FEED, b);
            return;
         end
         if (atyp == ATYP_DOMAIN) begin
            do b = 8'($urandom_range(DOMAIN_MIN, 255)); while (b == DOMAIN_DEL);
         end else begin
            b = 8'($urandom);
         end
         feed_byte(CMD_FEED, b);
      end
      case ($urandom_range(0, 9))
         0:       begin feed_byte(CMD_FEED, 8'h00); feed_byte(CMD_FEED, 8'h00); end
         1:       begin feed_byte(CMD_FEED, 8'hFF); feed_byte(CMD_FEED, 8'hFF); end
         2:       begin feed_byte(CMD_FEED, 8'h80); feed_byte(CMD_FEED, 8'h01); end
         default: begin feed_byte(CMD_FEED, 8'($urandom)); feed_byte(CMD_FEED, 8'($urandom)); end
      endcase
   endtask

   // compare result beats, then predict for request beats taken at this edge
   always @(posedge clock) begin : watch_channels
      rsp_payload_type want;
      rsp_payload_type seen;
      stim_row_type    row;
      string           bad;
      bit              was_open;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = {rsp_bus.status, rsp_bus.error_kind, rsp_bus.reply_code,
                    rsp_bus.address_type, rsp_bus.address_length,
                    rsp_bus.address_byte_valid, rsp_bus.address_byte,
                    rsp_bus.address_index, rsp_bus.dest_port};
            results_seen++;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("result beat %0d arrived with none pending: %s",
                           results_seen, result_text(seen));
            end else begin
               want = pending_results.pop_front();
               bad  = "";
               if (seen.status !== want.status)
                  bad = {bad, " status"};
               if (seen.error_kind !== want.error_kind)
                  bad = {bad, " error_kind"};
               if (seen.reply_code !== want.reply_code)
                  bad = {bad, " reply_code"};
               if (seen.address_type !== want.address_type)
                  bad = {bad, " address_type"};
               if (seen.address_length !== want.address_length)
                  bad = {bad, " address_length"};
               if (seen.address_byte_valid !== want.address_byte_valid)
                  bad = {bad, " address_byte_valid"};
               if (seen.address_byte !== want.address_byte)
                  bad = {bad, " address_byte"};
               if (seen.address_index !== want.address_index)
                  bad = {bad, " address_index"};
               if (seen.dest_port !== want.dest_port)
                  bad = {bad, " dest_port"};
               if (bad != "") begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("result beat %0d wrong in%s: expected %s, got %s",
                              results_seen, bad, result_text(want), result_text(seen));
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            row      = sent_rows.pop_front();
            was_open = (p_phase < PH_DONE);
            want     = parse_socks_byte(row.cmd, row.data);
            if (row.pinned) begin
               want.status     = row.status;
               want.error_kind = row.error_kind;
               want.reply_code = row.reply_code;
            end
            if (want.address_byte_valid) streamed_bytes++;
            if (was_open && want.status == ST_COMPLETE) completes++;
            if (was_open && want.status == ST_REJECTED) rejects++;
            pending_results.push_back(want);
            taken_reqs++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", stalled_cycles);
         $display("DONE: errors detected");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // result side: random stall bursts, plus long hold-offs to back up the input
   initial begin : result_sink
      int next_squeeze;
      next_squeeze = 150;
      rsp_bus.ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (next_squeeze != 0 && taken_reqs >= next_squeeze) begin
            next_squeeze = (next_squeeze == 150) ? 450 : 0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (bursty() && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      req_bus.valid   <= 1'b0;
      req_bus.cmd     <= CMD_FEED;
      req_bus.in_byte <= '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) feed(directed_rows[i]);
      while (fed_items < ITEM_TARGET) begin
         send_request();
         // trailing bytes land after a terminal state or mid-request
         if ($urandom_range(0, 1) == 0)
            repeat ($urandom_range(1, 3)) feed_byte(CMD_FEED, 8'($urandom));
      end
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("fed %0d request beats (%0d after a terminal state), checked %0d results",
               fed_items, ignored_items, results_seen);
      $display("requests completed %0d, rejected %0d, address bytes streamed %0d",
               completes, rejects, streamed_bytes);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("mismatches: %0d", mismatches);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: socks5_request_parser_unit.f
rtl/s5rp_pkg.sv
rtl/s5rp_if.sv
rtl/socks5_request_parser_unit.sv
tb/socks5_request_parser_unit_tb.sv
